// ----- rtl/core/stepper_half_step_ramp_driver_defines.svh -----
// assertion macros for the stepper half-step ramp driver checker
// no dependencies; included by the files that carry assertions
`ifndef STEPPER_HALF_STEP_RAMP_DRIVER_DEFINES_SVH
`define STEPPER_HALF_STEP_RAMP_DRIVER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SHSRD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SHSRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/shsrd_pkg.sv -----
// shared types, constants and functions of the stepper half-step ramp driver
// no dependencies
package shsrd_pkg;

    localparam int unsigned DELAY_W   = 8;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned COIL_W    = 4;
    localparam int unsigned PHASE_W   = 3;
    localparam int unsigned REQ_W     = 2;
    localparam int unsigned RUN_W     = 2;
    localparam int unsigned APB_AW    = 5;
    localparam int unsigned APB_DW    = 32;
    localparam int unsigned REG_IDX_W = 3;

    // register map indexes
    localparam logic [REG_IDX_W-1:0] REG_SLOW_DELAY  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FAST_DELAY  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RAMP_LENGTH = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_IDLE_BLINK  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RUN_BLINK   = 3'd4;

    // register reset values
    localparam logic [DELAY_W-1:0] SLOW_DELAY_RST  = 8'd10;
    localparam logic [DELAY_W-1:0] FAST_DELAY_RST  = 8'd2;
    localparam logic [COUNT_W-1:0] RAMP_LENGTH_RST = 16'd200;
    localparam logic [COUNT_W-1:0] IDLE_BLINK_RST  = 16'd500;
    localparam logic [COUNT_W-1:0] RUN_BLINK_RST   = 16'd100;

    localparam logic [DELAY_W-1:0] TICK_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // request codes
    localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RUN  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STOP = 2'd2;

    // reported run state codes
    localparam logic [RUN_W-1:0] RUN_STOPPED = 2'd0;
    localparam logic [RUN_W-1:0] RUN_ACCEL   = 2'd1;
    localparam logic [RUN_W-1:0] RUN_FULL    = 2'd2;
    localparam logic [RUN_W-1:0] RUN_DECEL   = 2'd3;

    typedef enum logic [3:0] {
        MODE_STOPPED = 4'b0001,
        MODE_ACCEL   = 4'b0010,
        MODE_FULL    = 4'b0100,
        MODE_DECEL   = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [DELAY_W-1:0] slow_delay;
        logic [DELAY_W-1:0] fast_delay;
        logic [COUNT_W-1:0] ramp_length;
        logic [COUNT_W-1:0] idle_blink_period;
        logic [COUNT_W-1:0] run_blink_period;
    } cfg_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             direction;
    } req_t;

    typedef struct packed {
        logic [COIL_W-1:0]  coil_drive;
        logic               step_taken;
        logic               led_level;
        logic [RUN_W-1:0]   run_state;
        logic [DELAY_W-1:0] step_delay;
    } res_t;

    // half-step coil pattern, bit0 A1, bit1 B1, bit2 A2, bit3 B2
    function automatic logic [COIL_W-1:0] coil_pattern(input logic ccw,
                                                      input logic [PHASE_W-1:0] phase);
        logic [PHASE_W-1:0] idx;
        logic [COIL_W-1:0]  pat;
        idx = ccw ? (3'd7 - phase) : phase;
        case (idx)
            3'd0:    pat = 4'h1;
            3'd1:    pat = 4'h3;
            3'd2:    pat = 4'h2;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h4;
            3'd5:    pat = 4'hC;
            3'd6:    pat = 4'h8;
            3'd7:    pat = 4'h9;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

    function automatic logic [RUN_W-1:0] mode_code(input mode_t mode);
        logic [RUN_W-1:0] code;
        case (mode)
            MODE_STOPPED: code = RUN_STOPPED;
            MODE_ACCEL:   code = RUN_ACCEL;
            MODE_FULL:    code = RUN_FULL;
            MODE_DECEL:   code = RUN_DECEL;
            default:      code = RUN_STOPPED;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/core/shsrd_if.sv -----
// valid/ready channel interfaces for request and result items
// no dependencies
interface shsrd_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic       direction;

    modport source (output valid, output req_type, output direction, input ready);
    modport sink (input valid, input req_type, input direction, output ready);
endinterface

interface shsrd_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] coil_drive;
    logic       step_taken;
    logic       led_level;
    logic [1:0] run_state;
    logic [7:0] step_delay;

    modport source (output valid, output coil_drive, output step_taken, output led_level,
                    output run_state, output step_delay, input ready);
    modport sink (input valid, input coil_drive, input step_taken, input led_level,
                  input run_state, input step_delay, output ready);
endinterface

// ----- rtl/core/shsrd_cfg_regs.sv -----
// apb configuration registers of the stepper driver
// depends on shsrd_pkg
module shsrd_cfg_regs
    import shsrd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx    = paddr[APB_AW-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_SLOW_DELAY:  cfg_next.slow_delay        = pwdata[DELAY_W-1:0];
                REG_FAST_DELAY:  cfg_next.fast_delay        = pwdata[DELAY_W-1:0];
                REG_RAMP_LENGTH: cfg_next.ramp_length       = pwdata[COUNT_W-1:0];
                REG_IDLE_BLINK:  cfg_next.idle_blink_period = pwdata[COUNT_W-1:0];
                REG_RUN_BLINK:   cfg_next.run_blink_period  = pwdata[COUNT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SLOW_DELAY:  prdata = {{(APB_DW-DELAY_W){1'b0}}, cfg_reg.slow_delay};
            REG_FAST_DELAY:  prdata = {{(APB_DW-DELAY_W){1'b0}}, cfg_reg.fast_delay};
            REG_RAMP_LENGTH: prdata = {{(APB_DW-COUNT_W){1'b0}}, cfg_reg.ramp_length};
            REG_IDLE_BLINK:  prdata = {{(APB_DW-COUNT_W){1'b0}}, cfg_reg.idle_blink_period};
            REG_RUN_BLINK:   prdata = {{(APB_DW-COUNT_W){1'b0}}, cfg_reg.run_blink_period};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slow_delay        <= SLOW_DELAY_RST;
            cfg_reg.fast_delay        <= FAST_DELAY_RST;
            cfg_reg.ramp_length       <= RAMP_LENGTH_RST;
            cfg_reg.idle_blink_period <= IDLE_BLINK_RST;
            cfg_reg.run_blink_period  <= RUN_BLINK_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/core/shsrd_core.sv -----
// motor state, ramp and heartbeat update, one item per accepted request
// depends on shsrd_pkg
module shsrd_core
    import shsrd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  req_t item,
    input  cfg_t cfg,
    output res_t res
);

    mode_t              mode_reg, mode_next;
    logic               rot_reg, rot_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [DELAY_W-1:0] delay_reg, delay_next;
    logic [COUNT_W-1:0] ramp_reg, ramp_next;
    logic [DELAY_W-1:0] tick_reg, tick_next;
    logic [COUNT_W-1:0] blink_reg, blink_next;
    logic               led_reg, led_next;
    logic [COIL_W-1:0]  coil_reg, coil_next;

    logic               stepped;
    logic [DELAY_W-1:0] tick_inc;
    logic [COUNT_W-1:0] blink_inc;
    logic [COUNT_W-1:0] ramp_inc;
    logic [COUNT_W-1:0] ramp_dec;
    logic [COUNT_W-1:0] blink_period;

    assign tick_inc     = (tick_reg == TICK_MAX) ? TICK_MAX : tick_reg + 8'd1;
    assign blink_inc    = (blink_reg == COUNT_MAX) ? COUNT_MAX : blink_reg + 16'd1;
    assign ramp_inc     = (ramp_reg == COUNT_MAX) ? COUNT_MAX : ramp_reg + 16'd1;
    assign ramp_dec     = ramp_reg - 16'd1;
    assign blink_period = (mode_reg == MODE_STOPPED) ? cfg.idle_blink_period
                                                     : cfg.run_blink_period;

    always_comb
    begin
        mode_next  = mode_reg;
        rot_next   = rot_reg;
        phase_next = phase_reg;
        delay_next = delay_reg;
        ramp_next  = ramp_reg;
        tick_next  = tick_reg;
        blink_next = blink_reg;
        led_next   = led_reg;
        coil_next  = coil_reg;
        stepped    = 1'b0;

        case (item.req_type)
            REQ_TICK:
            begin
                if (blink_inc >= blink_period)
                begin
                    blink_next = '0;
                    led_next   = ~led_reg;
                end
                else
                begin
                    blink_next = blink_inc;
                end
                if (mode_reg != MODE_STOPPED)
                begin
                    if (tick_inc < delay_reg)
                    begin
                        tick_next = tick_inc;
                    end
                    else
                    begin
                        tick_next  = '0;
                        stepped    = 1'b1;
                        coil_next  = coil_pattern(rot_reg, phase_reg);
                        phase_next = phase_reg + 3'd1;
                        case (mode_reg)
                            MODE_ACCEL:
                            begin
                                ramp_next = ramp_inc;
                                if (!ramp_inc[0] && (delay_reg > cfg.fast_delay))
                                    delay_next = delay_reg - 8'd1;
                                if (ramp_inc >= cfg.ramp_length)
                                    mode_next = MODE_FULL;
                            end
                            MODE_DECEL:
                            begin
                                if (ramp_reg == '0)
                                begin
                                    mode_next = MODE_STOPPED;
                                    coil_next = '0;
                                end
                                else
                                begin
                                    ramp_next = ramp_dec;
                                    if (!ramp_dec[0] && (delay_reg < cfg.slow_delay))
                                        delay_next = delay_reg + 8'd1;
                                    if (ramp_dec == '0)
                                    begin
                                        mode_next = MODE_STOPPED;
                                        coil_next = '0;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            REQ_RUN:
            begin
                if (mode_reg == MODE_STOPPED)
                begin
                    rot_next   = item.direction;
                    phase_next = '0;
                    ramp_next  = '0;
                    delay_next = cfg.slow_delay;
                    mode_next  = MODE_ACCEL;
                end
            end
            REQ_STOP:
            begin
                case (mode_reg)
                    MODE_FULL:
                    begin
                        ramp_next = cfg.ramp_length;
                        mode_next = MODE_DECEL;
                        if (cfg.ramp_length == '0)
                        begin
                            mode_next = MODE_STOPPED;
                            coil_next = '0;
                        end
                    end
                    MODE_ACCEL:
                    begin
                        if (ramp_reg == '0)
                        begin
                            mode_next = MODE_STOPPED;
                            coil_next = '0;
                        end
                        else
                        begin
                            mode_next = MODE_DECEL;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign res.coil_drive = coil_next;
    assign res.step_taken = stepped;
    assign res.led_level  = led_next;
    assign res.run_state  = mode_code(mode_next);
    assign res.step_delay = delay_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_STOPPED;
            rot_reg   <= 1'b0;
            phase_reg <= '0;
            delay_reg <= SLOW_DELAY_RST;
            ramp_reg  <= '0;
            tick_reg  <= '0;
            blink_reg <= '0;
            led_reg   <= 1'b0;
            coil_reg  <= '0;
        end
        else if (push)
        begin
            mode_reg  <= mode_next;
            rot_reg   <= rot_next;
            phase_reg <= phase_next;
            delay_reg <= delay_next;
            ramp_reg  <= ramp_next;
            tick_reg  <= tick_next;
            blink_reg <= blink_next;
            led_reg   <= led_next;
            coil_reg  <= coil_next;
        end
    end

endmodule

// ----- rtl/core/shsrd_out_buf.sv -----
// result register with skid stage, lets the request side take one more item while a result stalls
// depends on shsrd_pkg
module shsrd_out_buf
    import shsrd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_data,
    output logic push_ready,
    output logic pop_valid,
    input  logic pop_ready,
    output res_t pop_data
);

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_data_reg, out_data_next;
    res_t skid_data_reg, skid_data_next;
    logic out_free;

    assign push_ready = !skid_valid_reg;
    assign pop_valid  = out_valid_reg;
    assign pop_data   = out_data_reg;
    assign out_free   = !out_valid_reg || pop_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ----- rtl/core/stepper_half_step_ramp_driver.sv -----
// channel    dir  fields
// req_ch     in   req_type[1:0], direction
// res_ch     out  coil_drive[3:0], step_taken, led_level, run_state[1:0], step_delay[7:0]
// apb        in   psel, penable, pwrite, paddr[4:0], pwdata[31:0] / prdata, pready
//
// one request item per cycle while req_ch.ready is high; its result is registered
// the state update is a single compare/increment pass in shsrd_core
// a skid stage after the result register lets req_ch take an item while a result waits
// req_ch.ready drops only when both result and skid registers hold items
// reset loads register defaults: stopped, coils off, delay at slow_delay
//
// top level of the stepper half-step ramp driver
// depends on shsrd_pkg, shsrd_if, shsrd_cfg_regs, shsrd_core, shsrd_out_buf
module stepper_half_step_ramp_driver
    import shsrd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    shsrd_req_if.sink         req_ch,
    shsrd_res_if.source       res_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    cfg_t cfg;
    req_t item;
    res_t res;
    res_t res_out;
    logic push_ready;
    logic push;

    assign item.req_type  = req_ch.req_type;
    assign item.direction = req_ch.direction;
    assign req_ch.ready   = push_ready;
    assign push           = req_ch.valid && push_ready;

    shsrd_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    shsrd_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .item  (item),
        .cfg   (cfg),
        .res   (res)
    );

    shsrd_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (res),
        .push_ready (push_ready),
        .pop_valid  (res_ch.valid),
        .pop_ready  (res_ch.ready),
        .pop_data   (res_out)
    );

    assign res_ch.coil_drive = res_out.coil_drive;
    assign res_ch.step_taken = res_out.step_taken;
    assign res_ch.led_level  = res_out.led_level;
    assign res_ch.run_state  = res_out.run_state;
    assign res_ch.step_delay = res_out.step_delay;

endmodule

// ----- rtl/core/shsrd_checker.sv -----
// port-level checks of the stepper driver, bound to the top level
// depends on shsrd_pkg and stepper_half_step_ramp_driver_defines.svh
`include "stepper_half_step_ramp_driver_defines.svh"

module shsrd_checker
    import shsrd_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               res_valid,
    input logic               res_ready,
    input logic [COIL_W-1:0]  coil_drive,
    input logic               step_taken,
    input logic               led_level,
    input logic [RUN_W-1:0]   run_state,
    input logic [DELAY_W-1:0] step_delay
);

    logic [COIL_W+RUN_W+DELAY_W+1:0] res_bus;

    assign res_bus = {coil_drive, step_taken, led_level, run_state, step_delay};

    // stalled result holds
    `SHSRD_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_bus), "result changed while stalled")

    // an item taken with the result side empty shows in the next cycle
    `SHSRD_ASSERT_NEXT(a_latency, clk, rst_n, req_valid && req_ready && !res_valid, res_valid, "result missing one cycle after accept")

    // stopped motor keeps all coils off
    `SHSRD_ASSERT_NOW(a_stopped_off, clk, rst_n, res_valid && (run_state == RUN_STOPPED), coil_drive == '0, "coils energized while stopped")

    // a step while still moving energizes at least one coil
    `SHSRD_ASSERT_NOW(a_step_coil, clk, rst_n, res_valid && step_taken && (run_state != RUN_STOPPED), coil_drive != '0, "step with no coil on")

endmodule

bind stepper_half_step_ramp_driver shsrd_checker u_shsrd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_ch.valid),
    .req_ready  (req_ch.ready),
    .res_valid  (res_ch.valid),
    .res_ready  (res_ch.ready),
    .coil_drive (res_ch.coil_drive),
    .step_taken (res_ch.step_taken),
    .led_level  (res_ch.led_level),
    .run_state  (res_ch.run_state),
    .step_delay (res_ch.step_delay)
);

// ----- verif/stepper_half_step_ramp_driver_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the stepper half-step ramp driver: tick, run, stop and unused-code
// items are checked against a cycle-free model of the motor; needs shsrd_pkg, shsrd_if and the rtl
module stepper_half_step_ramp_driver_tb;
    import shsrd_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD = 120;

    localparam logic [COIL_W-1:0] HALF_STEP_CW [8] =
        '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};
    localparam logic [COIL_W-1:0] HALF_STEP_CCW [8] =
        '{4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1};

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    shsrd_req_if req_ch();
    shsrd_res_if res_ch();

    stepper_half_step_ramp_driver DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req_ch  (req_ch),
        .res_ch  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // register copy and motor model state
    cfg_t               reg_shadow;
    mode_t              pm_mode;
    logic               pm_ccw;
    logic [PHASE_W-1:0] pm_phase;
    logic [DELAY_W-1:0] pm_delay;
    logic [COUNT_W-1:0] pm_ramp;
    logic [DELAY_W-1:0] pm_ticks;
    logic [COUNT_W-1:0] pm_blink;
    logic               pm_led;
    logic [COIL_W-1:0]  pm_coils;

    req_t pending_events[$];
    res_t predicted_results[$];

    logic tx_gaps_on;
    logic rx_gaps_on;
    int   tx_gap;
    int   rx_gap;
    int   hold_left;
    int   hold_asked;
    int   hold_taken;
    int   quiet_cycles;
    int   error_count;
    int   items_sent;
    int   results_seen;
    int   steps_seen;
    int   full_seen;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic note_failure(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic void halt_coils();
        pm_mode  = MODE_STOPPED;
        pm_coils = '0;
    endfunction

    function automatic res_t advance_motor(input req_t ev);
        res_t               r;
        logic               stepped;
        logic [COUNT_W-1:0] period;
        stepped = 1'b0;
        case (ev.req_type)
            REQ_TICK:
            begin
                period = (pm_mode == MODE_STOPPED) ? reg_shadow.idle_blink_period
                                                   : reg_shadow.run_blink_period;
                if (pm_blink != COUNT_MAX)
                    pm_blink++;
                if (pm_blink >= period)
                begin
                    pm_blink = '0;
                    pm_led   = ~pm_led;
                end
                if (pm_mode != MODE_STOPPED)
                begin
                    if (pm_ticks != TICK_MAX)
                        pm_ticks++;
                    if (pm_ticks >= pm_delay)
                    begin
                        pm_ticks = '0;
                        stepped  = 1'b1;
                        pm_coils = pm_ccw ? HALF_STEP_CCW[pm_phase] : HALF_STEP_CW[pm_phase];
                        pm_phase++;
                        if (pm_mode == MODE_ACCEL)
                        begin
                            if (pm_ramp != COUNT_MAX)
                                pm_ramp++;
                            if (!pm_ramp[0] && pm_delay > reg_shadow.fast_delay)
                                pm_delay--;
                            if (pm_ramp >= reg_shadow.ramp_length)
                                pm_mode = MODE_FULL;
                        end
                        else if (pm_mode == MODE_DECEL)
                        begin
                            if (pm_ramp == '0)
                                halt_coils();
                            else
                            begin
                                pm_ramp--;
                                if (!pm_ramp[0] && pm_delay < reg_shadow.slow_delay)
                                    pm_delay++;
                                if (pm_ramp == '0)
                                    halt_coils();
                            end
                        end
                    end
                end
            end
            REQ_RUN:
            begin
                if (pm_mode == MODE_STOPPED)
                begin
                    pm_ccw   = ev.direction;
                    pm_phase = '0;
                    pm_ramp  = '0;
                    pm_delay = reg_shadow.slow_delay;
                    pm_mode  = MODE_ACCEL;
                end
            end
            REQ_STOP:
            begin
                if (pm_mode == MODE_FULL)
                begin
                    pm_ramp = reg_shadow.ramp_length;
                    pm_mode = MODE_DECEL;
                    if (pm_ramp == '0)
                        halt_coils();
                end
                else if (pm_mode == MODE_ACCEL)
                begin
                    if (pm_ramp == '0)
                        halt_coils();
                    else
                        pm_mode = MODE_DECEL;
                end
            end
            default:
            begin
            end
        endcase
        r.coil_drive = pm_coils;
        r.step_taken = stepped;
        r.led_level  = pm_led;
        case (pm_mode)
            MODE_ACCEL: r.run_state = RUN_ACCEL;
            MODE_FULL:  r.run_state = RUN_FULL;
            MODE_DECEL: r.run_state = RUN_DECEL;
            default:    r.run_state = RUN_STOPPED;
        endcase
        r.step_delay = pm_delay;
        return r;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.req_type  <= REQ_TICK;
            req_ch.direction <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predicted_results.push_back(advance_motor('{req_type: req_ch.req_type,
                                                            direction: req_ch.direction}));
                items_sent++;
                tx_gap = tx_gaps_on ? $urandom_range(0, 15) : 0;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_events.size() != 0)
                begin
                    req_ch.valid     <= 1'b1;
                    req_ch.req_type  <= pending_events[0].req_type;
                    req_ch.direction <= pending_events[0].direction;
                    void'(pending_events.pop_front());
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_taken <= 0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_taken != hold_asked)
        begin
            hold_left  <= LONG_HOLD;
            hold_taken <= hold_asked;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            rx_gap = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                results_seen++;
                if (res_ch.step_taken)
                    steps_seen++;
                if (res_ch.run_state == RUN_FULL)
                    full_seen++;
                if (predicted_results.size() == 0)
                    note_failure("result item with nothing predicted");
                else
                begin
                    want = predicted_results.pop_front();
                    if (res_ch.coil_drive !== want.coil_drive)
                        note_failure($sformatf("coil_drive got %h want %h",
                                               res_ch.coil_drive, want.coil_drive));
                    if (res_ch.step_taken !== want.step_taken)
                        note_failure($sformatf("step_taken got %b want %b",
                                               res_ch.step_taken, want.step_taken));
                    if (res_ch.led_level !== want.led_level)
                        note_failure($sformatf("led_level got %b want %b",
                                               res_ch.led_level, want.led_level));
                    if (res_ch.run_state !== want.run_state)
                        note_failure($sformatf("run_state got %0d want %0d",
                                               res_ch.run_state, want.run_state));
                    if (res_ch.step_delay !== want.step_delay)
                        note_failure($sformatf("step_delay got %0d want %0d",
                                               res_ch.step_delay, want.step_delay));
                end
                rx_gap = rx_gaps_on ? $urandom_range(0, 15) : 0;
            end
            else if (rx_gap != 0)
                rx_gap--;
            res_ch.ready <= (rx_gap == 0) && (hold_left == 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
            || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no traffic for %0d cycles", quiet_cycles);
            $display("[stepper_half_step_ramp_driver] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic void push_item(input logic [REQ_W-1:0] kind, input logic dir);
        pending_events.push_back('{req_type: kind, direction: dir});
    endfunction

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SLOW_DELAY:  reg_shadow.slow_delay        = val[DELAY_W-1:0];
            REG_FAST_DELAY:  reg_shadow.fast_delay        = val[DELAY_W-1:0];
            REG_RAMP_LENGTH: reg_shadow.ramp_length       = val[COUNT_W-1:0];
            REG_IDLE_BLINK:  reg_shadow.idle_blink_period = val[COUNT_W-1:0];
            REG_RUN_BLINK:   reg_shadow.run_blink_period  = val[COUNT_W-1:0];
            default:         ;
        endcase
    endtask

    task automatic write_config(input int slow, input int fast, input int ramp,
                                input int idle_period, input int run_period);
        apb_write(REG_SLOW_DELAY, slow);
        apb_write(REG_FAST_DELAY, fast);
        apb_write(REG_RAMP_LENGTH, ramp);
        apb_write(REG_IDLE_BLINK, idle_period);
        apb_write(REG_RUN_BLINK, run_period);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_events.size() != 0 || req_ch.valid || predicted_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // mostly run / ticks / optional stop / ticks sequences, the rest loose items of any kind
    task automatic queue_motion(input int count, input int span);
        int start;
        int k;
        int room;
        @(negedge clk);
        start = pending_events.size() + items_sent;
        while (pending_events.size() + items_sent - start < count)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                push_item(REQ_RUN, 1'($urandom_range(0, 1)));
                k = $urandom_range(0, span);
                room = count + start - items_sent - pending_events.size();
                if (k > room)
                    k = (room > 0) ? room : 0;
                repeat (k) push_item(REQ_TICK, 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 3) != 0)
                    push_item(REQ_STOP, 1'($urandom_range(0, 1)));
                k = $urandom_range(0, span);
                room = count + start - items_sent - pending_events.size();
                if (k > room)
                    k = (room > 0) ? room : 0;
                repeat (k) push_item(REQ_TICK, 1'($urandom_range(0, 1)));
            end
            else
                push_item(REQ_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_TICK;
        req_ch.direction = 1'b0;
        res_ch.ready     = 1'b0;
        tx_gaps_on       = 1'b1;
        rx_gaps_on       = 1'b1;
        hold_asked       = 0;
        error_count      = 0;
        items_sent       = 0;
        results_seen     = 0;
        steps_seen       = 0;
        full_seen        = 0;
        quiet_cycles     = 0;
        reg_shadow = '{slow_delay: SLOW_DELAY_RST, fast_delay: FAST_DELAY_RST,
                       ramp_length: RAMP_LENGTH_RST, idle_blink_period: IDLE_BLINK_RST,
                       run_blink_period: RUN_BLINK_RST};
        pm_mode  = MODE_STOPPED;
        pm_ccw   = 1'b0;
        pm_phase = '0;
        pm_delay = SLOW_DELAY_RST;
        pm_ramp  = '0;
        pm_ticks = '0;
        pm_blink = '0;
        pm_led   = 1'b0;
        pm_coils = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: unused code, idle stop, ignored run, stop at ramp start
        @(negedge clk);
        push_item(REQ_UNUSED, 1'b1);
        push_item(REQ_STOP, 1'b0);
        push_item(REQ_RUN, 1'b0);
        push_item(REQ_RUN, 1'b1);
        push_item(REQ_STOP, 1'b1);
        push_item(REQ_TICK, 1'b1);
        wait_drained();

        // short ramp: reach full speed, stop from full, stop while accelerating
        write_config(2, 1, 3, 1, 2);
        @(negedge clk);
        push_item(REQ_RUN, 1'b1);
        repeat (5) push_item(REQ_TICK, 1'b0);
        push_item(REQ_RUN, 1'b0);
        push_item(REQ_STOP, 1'b0);
        push_item(REQ_STOP, 1'b1);
        repeat (5) push_item(REQ_TICK, 1'b1);
        push_item(REQ_RUN, 1'b0);
        repeat (2) push_item(REQ_TICK, 1'b0);
        push_item(REQ_STOP, 1'b0);
        repeat (2) push_item(REQ_TICK, 1'b0);
        wait_drained();

        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        write_config(1, 1, 1, 1, 1);
        queue_motion(150, 12);

        // receiver stalls while the sender streams
        rx_gaps_on = 1'b1;
        hold_asked++;
        write_config(5, 2, 6, 3, 7);
        queue_motion(200, 40);

        tx_gaps_on = 1'b1;
        write_config(3, 5, 4, 2, 3);
        queue_motion(150, 30);

        write_config(SLOW_DELAY_RST, FAST_DELAY_RST, RAMP_LENGTH_RST,
                     IDLE_BLINK_RST, RUN_BLINK_RST);
        queue_motion(150, 60);

        tx_gaps_on = 1'b0;
        write_config(255, 255, 2, 65535, 65535);
        queue_motion(300, 600);

        tx_gaps_on = 1'b1;
        write_config(8, 1, 65535, 4, 9);
        queue_motion(150, 80);

        repeat (2)
        begin
            write_config($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 30),
                         $urandom_range(1, 40), $urandom_range(1, 40));
            queue_motion(75, 50);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (predicted_results.size() != 0)
            note_failure($sformatf("%0d predicted results never arrived",
                                   predicted_results.size()));
        $display("sent %0d items, checked %0d results: %0d coil steps, %0d at full speed",
                 items_sent, results_seen, steps_seen, full_seen);
        if (error_count == 0)
            $display("[stepper_half_step_ramp_driver] OK");
        else
            $display("[stepper_half_step_ramp_driver] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/shsrd_pkg.sv
rtl/core/shsrd_if.sv
rtl/core/shsrd_cfg_regs.sv
rtl/core/shsrd_core.sv
rtl/core/shsrd_out_buf.sv
rtl/core/stepper_half_step_ramp_driver.sv
rtl/core/shsrd_checker.sv
verif/stepper_half_step_ramp_driver_tb.sv
